/* sv/wts_pkg.sv */
// shared constants, types and codes of the window trend statistics block
package wts_pkg;

  // window depth and derived index width
  localparam int unsigned WINDOW = 10;
  localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = 7;

  // accumulator widths, sized for a window of up to 64 samples
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned XY_W   = 32;
  localparam int unsigned SX_W   = 12;
  localparam int unsigned SX2_W  = 18;
  localparam int unsigned LSUM_W = 31;
  localparam int unsigned LSQ_W  = 55;

  // shared divider widths
  localparam int unsigned DVD_W     = 64;
  localparam int unsigned DVS_W     = 24;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DEN,
    ST_PREP,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } wts_state_e;

  typedef enum logic [2:0] {
    JOB_REAL,
    JOB_PEND,
    JOB_TEMP,
    JOB_MEAN,
    JOB_VAR
  } wts_job_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/wts_in_if.sv */
// input channel of the window trend statistics block
interface wts_in_if;
  logic              valid;
  logic              ready;
  logic              disk_valid;
  logic [15:0]       realloc_count;
  logic [15:0]       pending_count;
  logic signed [7:0] temperature;
  logic              latency_valid;
  logic [23:0]       latency;

  modport source (
    output valid, disk_valid, realloc_count, pending_count, temperature,
    output latency_valid, latency,
    input  ready
  );
  modport sink (
    input  valid, disk_valid, realloc_count, pending_count, temperature,
    input  latency_valid, latency,
    output ready
  );
endinterface

/* sv/wts_out_if.sv */
// result channel of the window trend statistics block
interface wts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] realloc_trend;
  logic signed [31:0] pending_trend;
  logic signed [31:0] temp_trend;
  logic [23:0]        lat_avg;
  logic [23:0]        lat_dev;
  logic [6:0]         samples_held;

  modport source (
    output valid, realloc_trend, pending_trend, temp_trend,
    output lat_avg, lat_dev, samples_held,
    input  ready
  );
  modport sink (
    input  valid, realloc_trend, pending_trend, temp_trend,
    input  lat_avg, lat_dev, samples_held,
    output ready
  );
endinterface

/* sv/wts_div.sv */
// shared restoring divider, one quotient bit per cycle
module wts_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wts_pkg::div_req_t req_i,
  output wts_pkg::div_rsp_t rsp_o
);
  localparam int unsigned DVD_W     = wts_pkg::DVD_W;
  localparam int unsigned DVS_W     = wts_pkg::DVS_W;
  localparam int unsigned DIV_CNT_W = wts_pkg::DIV_CNT_W;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       diff;
  logic                 ge;

  // one shift and trial subtract
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = ~diff[DVS_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // a new division never starts on top of a running one
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");
  // done follows the last step of a division
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a division");
  // every division begins at step zero
  a_rose_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> cnt_q == '0) else $error("divider step count not cleared");

endmodule

/* sv/window_trend_statistics.sv */
// window trend statistics: walk of n samples, then five shared divisions and a square root;
// for a single sample only the mean is divided and the slopes and deviation are zero
// order from acceptance to result: window walk, denominator setup, the divisions, 24 square
//   root steps, then hand-over; a new sample is taken only once the result is handed over
// ready is high only while idle; a finished result waits in the output register
// reset empties the window and the output register; stored samples are not cleared
module window_trend_statistics (
  input  logic      clk_i,
  input  logic      rst_ni,
  wts_in_if.sink    in_i,
  wts_out_if.source out_o
);
  localparam int unsigned WINDOW = wts_pkg::WINDOW;
  localparam int unsigned IDX_W  = wts_pkg::IDX_W;
  localparam int unsigned CNT_W  = wts_pkg::CNT_W;
  localparam int unsigned SUM_W  = wts_pkg::SUM_W;
  localparam int unsigned XY_W   = wts_pkg::XY_W;
  localparam int unsigned SX_W   = wts_pkg::SX_W;
  localparam int unsigned SX2_W  = wts_pkg::SX2_W;
  localparam int unsigned LSUM_W = wts_pkg::LSUM_W;
  localparam int unsigned LSQ_W  = wts_pkg::LSQ_W;
  localparam int unsigned DVD_W  = wts_pkg::DVD_W;
  localparam int unsigned DVS_W  = wts_pkg::DVS_W;
  localparam int unsigned NUM_W  = XY_W + CNT_W + 2;

  wts_pkg::wts_state_e state_q, state_d;
  wts_pkg::wts_job_e   job_q, job_d;
  wts_pkg::div_req_t   div_req;
  wts_pkg::div_rsp_t   div_rsp;

  // sample window
  logic [15:0]       real_mem_q [WINDOW];
  logic [15:0]       pend_mem_q [WINDOW];
  logic signed [7:0] temp_mem_q [WINDOW];
  logic [23:0]       lat_mem_q  [WINDOW];

  logic [IDX_W-1:0] wpos_q, wpos_d, idx_q, idx_d, k_q, k_d;
  logic [CNT_W-1:0] fill_q, fill_d, n_q, n_d;

  logic signed [SUM_W-1:0] syr_q, syr_d, syp_q, syp_d, syt_q, syt_d;
  logic signed [XY_W-1:0]  sxyr_q, sxyr_d, sxyp_q, sxyp_d, sxyt_q, sxyt_d;
  logic [SX_W-1:0]         sx_q, sx_d;
  logic [SX2_W-1:0]        sx2_q, sx2_d;
  logic [LSUM_W-1:0]       lsum_q, lsum_d;
  logic [LSQ_W-1:0]        lsq_q, lsq_d;

  logic [DVS_W-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic [47:0]      v_q, v_d;
  logic [23:0]      r_q, r_d;
  logic [4:0]       bit_q, bit_d;
  logic [31:0]      res_r_q, res_r_d, res_p_q, res_p_d, res_t_q, res_t_d;
  logic [23:0]      mean_q, mean_d;

  logic               out_valid_q, out_valid_d, out_load;
  logic signed [31:0] out_r_q, out_p_q, out_t_q;
  logic [23:0]        out_mean_q, out_sd_q;
  logic [CNT_W-1:0]   out_n_q;

  logic             in_fire;
  logic [CNT_W-1:0] fill_next;
  logic [IDX_W-1:0] wpos_next, start_idx, idx_next;

  // walk datapath
  logic signed [16:0]      yr, yp;
  logic signed [7:0]       yt;
  logic signed [IDX_W:0]   kk;
  logic signed [IDX_W+17:0] pr_r, pr_p;
  logic signed [IDX_W+8:0] pr_t;
  logic [23:0]             lat_w;
  logic [47:0]             lat_sq;
  logic [2*IDX_W-1:0]      ksq;

  // setup datapath
  logic signed [SUM_W-1:0]      sy_sel;
  logic signed [XY_W-1:0]       sxy_sel;
  logic signed [CNT_W:0]        n_s;
  logic signed [SX_W:0]         sx_s;
  logic signed [XY_W+CNT_W:0]   nsxy;
  logic signed [SX_W+SUM_W:0]   sxsy;
  logic signed [NUM_W-1:0]      num_w, neg_num;
  logic [NUM_W-2:0]             mag_w;
  logic [SX2_W+CNT_W-1:0]       nsx2;
  logic [2*SX_W-1:0]            sxsq;
  logic [SX2_W+CNT_W-1:0]       den_w;
  logic [LSQ_W+CNT_W-1:0]       nlsq, lsum2, a_w;
  logic [2*CNT_W-1:0]           b_w;
  logic [DVD_W-1:0]             q_neg;
  logic [23:0]                  cand;
  logic [47:0]                  csq;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == wts_pkg::ST_IDLE);

  // write pointer and fill level after this item
  assign fill_next = (fill_q < CNT_W'(WINDOW)) ? fill_q + 1'b1 : fill_q;
  assign wpos_next = (wpos_q == IDX_W'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
  assign start_idx = (fill_next == CNT_W'(WINDOW)) ? wpos_next : '0;
  assign idx_next  = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;

  // window write
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      real_mem_q[wpos_q] <= in_i.disk_valid ? in_i.realloc_count : 16'h0000;
      pend_mem_q[wpos_q] <= in_i.disk_valid ? in_i.pending_count : 16'h0000;
      temp_mem_q[wpos_q] <= in_i.disk_valid ? in_i.temperature : 8'sh00;
      lat_mem_q[wpos_q]  <= in_i.latency_valid ? in_i.latency : 24'h000000;
    end
  end

  // oldest-first read and per-sample products
  assign yr     = $signed({1'b0, real_mem_q[idx_q]});
  assign yp     = $signed({1'b0, pend_mem_q[idx_q]});
  assign yt     = temp_mem_q[idx_q];
  assign kk     = $signed({1'b0, k_q});
  assign pr_r   = kk * yr;
  assign pr_p   = kk * yp;
  assign pr_t   = kk * yt;
  assign lat_w  = lat_mem_q[idx_q];
  assign lat_sq = lat_w * lat_w;
  assign ksq    = k_q * k_q;

  // slope numerator for the current job
  always_comb begin
    case (job_q)
      wts_pkg::JOB_PEND: begin
        sy_sel  = syp_q;
        sxy_sel = sxyp_q;
      end
      wts_pkg::JOB_TEMP: begin
        sy_sel  = syt_q;
        sxy_sel = sxyt_q;
      end
      default: begin
        sy_sel  = syr_q;
        sxy_sel = sxyr_q;
      end
    endcase
  end

  assign n_s     = $signed({1'b0, n_q});
  assign sx_s    = $signed({1'b0, sx_q});
  assign nsxy    = n_s * sxy_sel;
  assign sxsy    = sx_s * sy_sel;
  assign num_w   = nsxy - sxsy;
  assign neg_num = -num_w;
  assign mag_w   = num_w[NUM_W-1] ? neg_num[NUM_W-2:0] : num_w[NUM_W-2:0];

  // slope denominator and variance terms
  assign nsx2  = n_q * sx2_q;
  assign sxsq  = sx_q * sx_q;
  assign den_w = nsx2 - (SX2_W + CNT_W)'(sxsq);
  assign nlsq  = n_q * lsq_q;
  assign lsum2 = lsum_q * lsum_q;
  assign a_w   = nlsq - lsum2;
  assign b_w   = n_q * (n_q - 1'b1);

  assign q_neg = -div_rsp.quotient;

  // square root trial
  assign cand = r_q | (24'd1 << bit_q);
  assign csq  = cand * cand;

  wts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    wpos_d  = wpos_q;
    fill_d  = fill_q;
    n_d     = n_q;
    idx_d   = idx_q;
    k_d     = k_q;
    syr_d   = syr_q;
    syp_d   = syp_q;
    syt_d   = syt_q;
    sxyr_d  = sxyr_q;
    sxyp_d  = sxyp_q;
    sxyt_d  = sxyt_q;
    sx_d    = sx_q;
    sx2_d   = sx2_q;
    lsum_d  = lsum_q;
    lsq_d   = lsq_q;
    den_d   = den_q;
    neg_d   = neg_q;
    v_d     = v_q;
    r_d     = r_q;
    bit_d   = bit_q;
    res_r_d = res_r_q;
    res_p_d = res_p_q;
    res_t_d = res_t_q;
    mean_d  = mean_q;
    out_load = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'({mag_w, 8'h00});
    div_req.divisor  = den_q;

    unique case (state_q)
      wts_pkg::ST_IDLE: begin
        if (in_fire) begin
          fill_d  = fill_next;
          n_d     = fill_next;
          wpos_d  = wpos_next;
          idx_d   = start_idx;
          k_d     = '0;
          syr_d   = '0;
          syp_d   = '0;
          syt_d   = '0;
          sxyr_d  = '0;
          sxyp_d  = '0;
          sxyt_d  = '0;
          sx_d    = '0;
          sx2_d   = '0;
          lsum_d  = '0;
          lsq_d   = '0;
          state_d = wts_pkg::ST_WALK;
        end
      end
      wts_pkg::ST_WALK: begin
        syr_d  = syr_q + SUM_W'(yr);
        syp_d  = syp_q + SUM_W'(yp);
        syt_d  = syt_q + SUM_W'(yt);
        sxyr_d = sxyr_q + XY_W'(pr_r);
        sxyp_d = sxyp_q + XY_W'(pr_p);
        sxyt_d = sxyt_q + XY_W'(pr_t);
        sx_d   = sx_q + SX_W'(k_q);
        sx2_d  = sx2_q + SX2_W'(ksq);
        lsum_d = lsum_q + LSUM_W'(lat_w);
        lsq_d  = lsq_q + LSQ_W'(lat_sq);
        idx_d  = idx_next;
        k_d    = k_q + 1'b1;
        if (CNT_W'(k_q) == n_q - 1'b1) begin
          state_d = wts_pkg::ST_DEN;
        end
      end
      wts_pkg::ST_DEN: begin
        den_d   = DVS_W'(den_w);
        job_d   = wts_pkg::JOB_REAL;
        state_d = wts_pkg::ST_PREP;
      end
      wts_pkg::ST_PREP: begin
        unique case (job_q) inside
          wts_pkg::JOB_REAL, wts_pkg::JOB_PEND, wts_pkg::JOB_TEMP: begin
            if (n_q < CNT_W'(2)) begin
              // too few samples: slope is zero, no division
              unique case (job_q)
                wts_pkg::JOB_REAL: begin
                  res_r_d = '0;
                  job_d   = wts_pkg::JOB_PEND;
                end
                wts_pkg::JOB_PEND: begin
                  res_p_d = '0;
                  job_d   = wts_pkg::JOB_TEMP;
                end
                default: begin
                  res_t_d = '0;
                  job_d   = wts_pkg::JOB_MEAN;
                end
              endcase
            end else begin
              neg_d         = num_w[NUM_W-1];
              div_req.start = 1'b1;
              state_d       = wts_pkg::ST_DIV;
            end
          end
          wts_pkg::JOB_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(lsum_q);
            div_req.divisor  = DVS_W'(n_q);
            state_d          = wts_pkg::ST_DIV;
          end
          wts_pkg::JOB_VAR: begin
            if (n_q < CNT_W'(2)) begin
              // single sample: deviation is zero at hand-over
              state_d = wts_pkg::ST_FIN;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DVD_W'(a_w);
              div_req.divisor  = DVS_W'(b_w);
              state_d          = wts_pkg::ST_DIV;
            end
          end
          default: begin
            state_d = wts_pkg::ST_IDLE;
          end
        endcase
      end
      wts_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          unique case (job_q)
            wts_pkg::JOB_REAL: begin
              res_r_d = neg_q ? q_neg[31:0] : div_rsp.quotient[31:0];
              job_d   = wts_pkg::JOB_PEND;
              state_d = wts_pkg::ST_PREP;
            end
            wts_pkg::JOB_PEND: begin
              res_p_d = neg_q ? q_neg[31:0] : div_rsp.quotient[31:0];
              job_d   = wts_pkg::JOB_TEMP;
              state_d = wts_pkg::ST_PREP;
            end
            wts_pkg::JOB_TEMP: begin
              res_t_d = neg_q ? q_neg[31:0] : div_rsp.quotient[31:0];
              job_d   = wts_pkg::JOB_MEAN;
              state_d = wts_pkg::ST_PREP;
            end
            wts_pkg::JOB_MEAN: begin
              mean_d  = div_rsp.quotient[23:0];
              job_d   = wts_pkg::JOB_VAR;
              state_d = wts_pkg::ST_PREP;
            end
            wts_pkg::JOB_VAR: begin
              v_d     = div_rsp.quotient[47:0];
              r_d     = '0;
              bit_d   = 5'd23;
              state_d = wts_pkg::ST_SQRT;
            end
            default: begin
              state_d = wts_pkg::ST_IDLE;
            end
          endcase
        end
      end
      wts_pkg::ST_SQRT: begin
        if (csq <= v_q) begin
          r_d = cand;
        end
        if (bit_q == '0) begin
          state_d = wts_pkg::ST_FIN;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      wts_pkg::ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = wts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wts_pkg::ST_IDLE;
      end
    endcase
  end

  // output slot
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wts_pkg::ST_IDLE;
      job_q       <= wts_pkg::JOB_REAL;
      wpos_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      wpos_q      <= wpos_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    idx_q   <= idx_d;
    k_q     <= k_d;
    syr_q   <= syr_d;
    syp_q   <= syp_d;
    syt_q   <= syt_d;
    sxyr_q  <= sxyr_d;
    sxyp_q  <= sxyp_d;
    sxyt_q  <= sxyt_d;
    sx_q    <= sx_d;
    sx2_q   <= sx2_d;
    lsum_q  <= lsum_d;
    lsq_q   <= lsq_d;
    den_q   <= den_d;
    neg_q   <= neg_d;
    v_q     <= v_d;
    r_q     <= r_d;
    bit_q   <= bit_d;
    res_r_q <= res_r_d;
    res_p_q <= res_p_d;
    res_t_q <= res_t_d;
    mean_q  <= mean_d;
    if (out_load) begin
      out_r_q    <= res_r_q;
      out_p_q    <= res_p_q;
      out_t_q    <= res_t_q;
      out_mean_q <= mean_q;
      out_sd_q   <= (n_q < CNT_W'(2)) ? 24'h000000 : r_q;
      out_n_q    <= n_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.realloc_trend = out_r_q;
  assign out_o.pending_trend = out_p_q;
  assign out_o.temp_trend    = out_t_q;
  assign out_o.lat_avg       = out_mean_q;
  assign out_o.lat_dev       = out_sd_q;
  assign out_o.samples_held  = out_n_q;

  // an accepted item always starts the window walk
  a_fire_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == wts_pkg::ST_WALK) else $error("item accepted without walk");
  // fill level never passes the window depth
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW)) else $error("fill level beyond window");
  // divider results only arrive while the sequencer waits for them
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == wts_pkg::ST_DIV) else $error("unexpected divider result");
  // a presented result carries a sample count within the window
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.samples_held != '0) && (out_o.samples_held <= CNT_W'(WINDOW)))
    else $error("bad sample count on result");

endmodule

/* tb/sv/window_trend_statistics_tb.sv */
// testbench for the window trend statistics block: directed and random samples against a predictor
`timescale 1ns / 100ps

module window_trend_statistics_tb;

  typedef struct packed {
    logic signed [31:0] realloc_trend;
    logic signed [31:0] pending_trend;
    logic signed [31:0] temp_trend;
    logic [23:0]        lat_avg;
    logic [23:0]        lat_dev;
    logic [6:0]         samples_held;
  } trend_t;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   idle_free;
  int   hold_off;
  int   quiet_cycles;
  bit   timed_out;

  wts_in_if  in_ch ();
  wts_out_if out_ch ();

  window_trend_statistics DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // predictor state: window contents, write pointer and fill level
  logic [15:0]       win_realloc [wts_pkg::WINDOW];
  logic [15:0]       win_pending [wts_pkg::WINDOW];
  logic signed [7:0] win_temp    [wts_pkg::WINDOW];
  logic [23:0]       win_latency [wts_pkg::WINDOW];
  int unsigned       wr_pos;
  int unsigned       fill;
  trend_t            expected_trends [$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // q8 least-squares slope, truncated toward zero
  function automatic logic signed [31:0] trend_slope(longint y[wts_pkg::WINDOW],
                                                     int unsigned n);
    longint sy, sxy, sx, sx2, den, num;
    sy  = 0;
    sxy = 0;
    if (n < 2) return '0;
    for (int i = 0; i < n; i++) begin
      sy  += y[i];
      sxy += i * y[i];
    end
    sx  = n * (n - 1) / 2;
    sx2 = (n - 1) * n * (2 * n - 1) / 6;
    den = n * sx2 - sx * sx;
    num = n * sxy - sx * sy;
    return 32'((num * 256) / den);
  endfunction

  // store one sample and work out the statistics it causes
  function automatic void predict_trend(logic dv, logic [15:0] rc, logic [15:0] pc,
                                        logic signed [7:0] tc, logic lv, logic [23:0] lat);
    longint yr[wts_pkg::WINDOW], yp[wts_pkg::WINDOW], yt[wts_pkg::WINDOW];
    longint unsigned lsum, lsq, a, b, r, cand;
    int unsigned start, idx;
    trend_t t;
    lsum = 0;
    lsq  = 0;
    r    = 0;
    win_realloc[wr_pos] = dv ? rc : '0;
    win_pending[wr_pos] = dv ? pc : '0;
    win_temp[wr_pos]    = dv ? tc : '0;
    win_latency[wr_pos] = lv ? lat : '0;
    wr_pos = (wr_pos + 1) % wts_pkg::WINDOW;
    if (fill < wts_pkg::WINDOW) fill++;
    start = (fill < wts_pkg::WINDOW) ? 0 : wr_pos;
    for (int k = 0; k < wts_pkg::WINDOW; k++) begin
      yr[k] = 0; yp[k] = 0; yt[k] = 0;
    end
    for (int k = 0; k < fill; k++) begin
      idx   = (start + k) % wts_pkg::WINDOW;
      yr[k] = win_realloc[idx];
      yp[k] = win_pending[idx];
      yt[k] = win_temp[idx];
      lsum += win_latency[idx];
      lsq  += longint'(win_latency[idx]) * win_latency[idx];
    end
    t.realloc_trend = trend_slope(yr, fill);
    t.pending_trend = trend_slope(yp, fill);
    t.temp_trend    = trend_slope(yt, fill);
    t.lat_avg       = 24'(lsum / fill);
    if (fill >= 2) begin
      a = fill * lsq - lsum * lsum;
      b = fill * (fill - 1);
      for (int bit_i = 23; bit_i >= 0; bit_i--) begin
        cand = r | (64'd1 << bit_i);
        if (cand * cand * b <= a) r = cand;
      end
    end
    t.lat_dev      = 24'(r);
    t.samples_held = 7'(fill);
    expected_trends.push_back(t);
  endfunction

  // send one sample, with random gaps before it unless idle_free is set
  task automatic send_sample(logic dv, logic [15:0] rc, logic [15:0] pc,
                             logic signed [7:0] tc, logic lv, logic [23:0] lat);
    while (idle_free == 0 && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.disk_valid    <= dv;
    in_ch.realloc_count <= rc;
    in_ch.pending_count <= pc;
    in_ch.temperature   <= tc;
    in_ch.latency_valid <= lv;
    in_ch.latency       <= lat;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_trend(dv, rc, pc, tc, lv, lat);
  endtask

  task automatic send_random(int unsigned count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: send_sample(1'b1, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1, 24'($urandom));
        1: send_sample(1'($urandom_range(1)), 16'($urandom_range(20)),
                       16'($urandom_range(20)), 8'($urandom_range(60)),
                       1'($urandom_range(1)), 24'($urandom_range(4096)));
        2: send_sample(1'b1, 16'(100 + 7 * i), 16'(i), 8'(30 + (i % 20)), 1'b1,
                       24'($urandom_range(2000)));
        default: send_sample(1'($urandom_range(1)), {16{1'b1}}, 16'($urandom), 8'($urandom),
                             1'($urandom_range(1)), {24{1'b1}} - 24'($urandom_range(3)));
      endcase
    end
  endtask

  // extremes, invalid fields and the first fill of the window
  task automatic test_directed();
    send_sample(1'b1, 16'hFFFF, 16'h0000, -8'sd128, 1'b1, 24'hFFFFFF);
    send_sample(1'b1, 16'h0000, 16'hFFFF, 8'sd127, 1'b1, 24'h000000);
    send_sample(1'b0, 16'hFFFF, 16'hFFFF, 8'sd127, 1'b0, 24'hFFFFFF);
    send_sample(1'b1, 16'hAAAA, 16'h5555, -8'sd1, 1'b1, 24'hAAAAAA);
    send_sample(1'b1, 16'h5555, 16'hAAAA, 8'sd0, 1'b1, 24'h555555);
    for (int i = 0; i < 10; i++)
      send_sample(1'b1, 16'(i * 1000), 16'(65535 - i * 3000), 8'(-100 + i * 20), i[0],
                  24'(i * 1677721));
    for (int i = 0; i < 6; i++)
      send_sample(1'b1, 16'hFFFF, 16'hFFFF, -8'sd128, 1'b1, 24'hFFFFFF);
  endtask

  // window wrapped many times over with no idling on either side
  task automatic test_back_to_back();
    idle_free = 1;
    send_random(60);
    idle_free = 0;
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    hold_off = 1500;
    send_random(8);
  endtask

  task automatic test_random();
    send_random(320);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_trends.size() == 0) begin
        $error("result with no sample pending");
        errors++;
      end else begin
        trend_t e;
        e = expected_trends.pop_front();
        if (out_ch.realloc_trend !== e.realloc_trend) begin
          $error("realloc_trend exp %0d got %0d", e.realloc_trend, out_ch.realloc_trend);
          errors++;
        end
        if (out_ch.pending_trend !== e.pending_trend) begin
          $error("pending_trend exp %0d got %0d", e.pending_trend, out_ch.pending_trend);
          errors++;
        end
        if (out_ch.temp_trend !== e.temp_trend) begin
          $error("temp_trend exp %0d got %0d", e.temp_trend, out_ch.temp_trend);
          errors++;
        end
        if (out_ch.lat_avg !== e.lat_avg) begin
          $error("lat_avg exp %0d got %0d", e.lat_avg, out_ch.lat_avg);
          errors++;
        end
        if (out_ch.lat_dev !== e.lat_dev) begin
          $error("lat_dev exp %0d got %0d", e.lat_dev, out_ch.lat_dev);
          errors++;
        end
        if (out_ch.samples_held !== e.samples_held) begin
          $error("samples_held exp %0d got %0d", e.samples_held, out_ch.samples_held);
          errors++;
        end
      end
    end
  end

  // receiver ready: random stalls, a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off     <= hold_off - 1;
    end else begin
      out_ch.ready <= (idle_free != 0) || ($urandom_range(99) >= 29);
    end
  end

  // watchdog on cycles with nothing accepted outside a hold-off
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) timed_out = 1'b1;
  end

  initial begin
    errors       = 0;
    idle_free    = 0;
    hold_off     = 0;
    quiet_cycles = 0;
    timed_out    = 1'b0;
    wr_pos       = 0;
    fill         = 0;
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.disk_valid     = 1'b0;
    in_ch.realloc_count  = '0;
    in_ch.pending_count  = '0;
    in_ch.temperature    = '0;
    in_ch.latency_valid  = 1'b0;
    in_ch.latency        = '0;
    out_ch.ready         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      begin
        test_directed();
        test_back_to_back();
        test_backpressure();
        test_random();
        in_ch.valid <= 1'b0;
        while (expected_trends.size() != 0) @(posedge clk_i);
        repeat (400) @(posedge clk_i);
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("window_trend_statistics_tb failed");
    end else if (errors == 0 && expected_trends.size() == 0) begin
      $display("window_trend_statistics_tb passed");
    end else begin
      $display("window_trend_statistics_tb failed");
    end
    $finish;
  end

endmodule
